/* hdl/bounded_deque_positional_ops_core_assert.svh */
// ----------------------------------------------------------------------------
// bounded_deque_positional_ops_core_assert
// Assertion macros for the bounded deque core checker. Each macro expands to
// one labeled concurrent assertion on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_DEQUE_POSITIONAL_OPS_CORE_ASSERT_SVH
`define BOUNDED_DEQUE_POSITIONAL_OPS_CORE_ASSERT_SVH

// Same-cycle implication.
`define BDQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BDQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/bdq_pkg.sv */
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded deque core and its checker.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 16;
    localparam int DATA_W        = 32;
    localparam int COUNT_OUT_W   = 5;

    typedef enum logic [2:0] {
        REQ_PUSH_FRONT      = 3'd0,
        REQ_PUSH_BACK       = 3'd1,
        REQ_INS_SECOND      = 3'd2,
        REQ_INS_BEFORE_LAST = 3'd3,
        REQ_POP_FRONT       = 3'd4,
        REQ_REMOVE_SECOND   = 3'd5,
        REQ_POP_BACK        = 3'd6,
        REQ_DUMP            = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_SHORT = 2'd2
    } status_t;

    typedef struct packed {
        logic [2:0]               req_type;
        logic signed [DATA_W-1:0] value_in;
    } req_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] value_out;
        logic [1:0]               status;
        logic [COUNT_OUT_W-1:0]   entry_count;
        logic                     last_of_run;
    } rsp_item_t;

endpackage

/* hdl/bounded_deque_positional_ops_core.sv */
// ----------------------------------------------------------------------------
// bounded_deque_positional_ops_core
// Bounded double-ended list in a ring store with positional inserts/removals.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_stall | bdq_pkg::req_item_t
//  rsp     | out       | rsp_valid/rsp_stall | bdq_pkg::rsp_item_t
//
//  Push front, push back, a dump of an empty list and every rejected request
//  go straight to S_OUT. Pop front and pop back pass through the read state S_RD;
//  insert second, insert before last and remove second pass through S_RD and the
//  write state S_W2, set by the single read and single write port of the store.
//  A dump gives one response per cycle while rsp_stall is low.
//  Reset clears head, count and sequencer; the store itself is not cleared.
//  One request is in flight at a time; req_stall is high until its last response.
// ----------------------------------------------------------------------------
module bounded_deque_positional_ops_core #(
    parameter int DEPTH = bdq_pkg::DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_stall,
    input  bdq_pkg::req_item_t  req,
    output logic                rsp_valid,
    input  logic                rsp_stall,
    output bdq_pkg::rsp_item_t  rsp
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int DW = bdq_pkg::DATA_W;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_RD   = 5'b00010,
        S_W2   = 5'b00100,
        S_OUT  = 5'b01000,
        S_DUMP = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    bdq_pkg::req_t     op_reg, op_next;
    logic [DW-1:0]     val_reg, val_next;
    logic [AW-1:0]     addr_a_reg, addr_a_next;
    logic [AW-1:0]     addr_b_reg, addr_b_next;
    logic [DW-1:0]     res_val_reg, res_val_next;
    bdq_pkg::status_t  res_status_reg, res_status_next;
    logic [AW-1:0]     dptr_reg, dptr_next;
    logic [AW-1:0]     dpos_reg, dpos_next;

    logic [DW-1:0]     mem [DEPTH];
    logic [DW-1:0]     mem_q;
    logic              we;
    logic [AW-1:0]     waddr;
    logic [DW-1:0]     wdata;
    logic [AW-1:0]     raddr;

    logic [AW-1:0]     head_inc;
    logic [AW-1:0]     head_dec;
    logic [AW-1:0]     slot_last;
    logic [AW-1:0]     slot_end;
    logic [AW-1:0]     dptr_inc;
    logic              dump_last;

    // Ring position base + off; base + off stays below twice the depth.
    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(base) + SW'(off);
        if (sum >= SW'(DEPTH))
        begin
            sum = sum - SW'(DEPTH);
        end
        return sum[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] ring_dec(input logic [AW-1:0] base);
        logic [AW-1:0] res;
        if (base == '0)
        begin
            res = AW'(DEPTH - 1);
        end
        else
        begin
            res = base - AW'(1);
        end
        return res;
    endfunction

    assign head_inc  = ring_add(head_reg, CW'(1));
    assign head_dec  = ring_dec(head_reg);
    assign slot_last = ring_add(head_reg, count_reg - CW'(1));
    assign slot_end  = ring_add(head_reg, count_reg);
    assign dptr_inc  = ring_add(dptr_reg, CW'(1));
    assign dump_last = (CW'(dpos_reg) + CW'(1)) == count_reg;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        op_next         = op_reg;
        val_next        = val_reg;
        addr_a_next     = addr_a_reg;
        addr_b_next     = addr_b_reg;
        res_val_next    = res_val_reg;
        res_status_next = res_status_reg;
        dptr_next       = dptr_reg;
        dpos_next       = dpos_reg;
        we              = 1'b0;
        waddr           = slot_end;
        wdata           = req.value_in;
        raddr           = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next         = bdq_pkg::req_t'(req.req_type);
                    val_next        = req.value_in;
                    res_val_next    = '0;
                    res_status_next = bdq_pkg::ST_OK;
                    state_next      = S_OUT;
                    if (!req.req_type[2] && count_reg == CW'(DEPTH))
                    begin
                        res_status_next = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        unique case (bdq_pkg::req_t'(req.req_type))
                            bdq_pkg::REQ_PUSH_FRONT:
                            begin
                                we         = 1'b1;
                                waddr      = head_dec;
                                head_next  = head_dec;
                                count_next = count_reg + CW'(1);
                            end
                            bdq_pkg::REQ_PUSH_BACK:
                            begin
                                we         = 1'b1;
                                waddr      = slot_end;
                                count_next = count_reg + CW'(1);
                            end
                            bdq_pkg::REQ_INS_SECOND:
                            begin
                                // The first entry moves one slot toward the front,
                                // and the new value takes its old slot.
                                if (count_reg == '0)
                                begin
                                    res_status_next = bdq_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    raddr       = head_reg;
                                    addr_a_next = head_reg;
                                    addr_b_next = head_dec;
                                    state_next  = S_RD;
                                end
                            end
                            bdq_pkg::REQ_INS_BEFORE_LAST:
                            begin
                                // The last entry moves one slot back; this also
                                // puts the value in front on a one-entry list.
                                if (count_reg == '0)
                                begin
                                    res_status_next = bdq_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    raddr       = slot_last;
                                    addr_a_next = slot_last;
                                    addr_b_next = slot_end;
                                    state_next  = S_RD;
                                end
                            end
                            bdq_pkg::REQ_POP_FRONT:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_status_next = bdq_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    raddr      = head_reg;
                                    state_next = S_RD;
                                end
                            end
                            bdq_pkg::REQ_REMOVE_SECOND:
                            begin
                                // The first entry is copied over the second, and
                                // the head then steps past the old first slot.
                                if (count_reg < CW'(2))
                                begin
                                    res_status_next = bdq_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    raddr       = head_inc;
                                    addr_a_next = head_inc;
                                    addr_b_next = head_reg;
                                    state_next  = S_RD;
                                end
                            end
                            bdq_pkg::REQ_POP_BACK:
                            begin
                                if (count_reg == '0)
                                begin
                                    res_status_next = bdq_pkg::ST_SHORT;
                                end
                                else
                                begin
                                    raddr      = slot_last;
                                    state_next = S_RD;
                                end
                            end
                            bdq_pkg::REQ_DUMP:
                            begin
                                if (count_reg != '0)
                                begin
                                    raddr      = head_reg;
                                    dptr_next  = head_reg;
                                    dpos_next  = '0;
                                    state_next = S_DUMP;
                                end
                            end
                        endcase
                    end
                end
            end

            S_RD:
            begin
                state_next = S_OUT;
                case (op_reg) inside
                    bdq_pkg::REQ_INS_SECOND, bdq_pkg::REQ_INS_BEFORE_LAST:
                    begin
                        we         = 1'b1;
                        waddr      = addr_b_reg;
                        wdata      = mem_q;
                        state_next = S_W2;
                    end
                    bdq_pkg::REQ_POP_FRONT:
                    begin
                        res_val_next = mem_q;
                        head_next    = head_inc;
                        count_next   = count_reg - CW'(1);
                    end
                    bdq_pkg::REQ_POP_BACK:
                    begin
                        res_val_next = mem_q;
                        count_next   = count_reg - CW'(1);
                    end
                    bdq_pkg::REQ_REMOVE_SECOND:
                    begin
                        res_val_next = mem_q;
                        raddr        = addr_b_reg;
                        state_next   = S_W2;
                    end
                    default:
                    begin
                        state_next = S_OUT;
                    end
                endcase
            end

            S_W2:
            begin
                we         = 1'b1;
                waddr      = addr_a_reg;
                wdata      = (op_reg == bdq_pkg::REQ_REMOVE_SECOND) ? mem_q : val_reg;
                state_next = S_OUT;
                case (op_reg)
                    bdq_pkg::REQ_INS_SECOND:
                    begin
                        head_next  = addr_b_reg;
                        count_next = count_reg + CW'(1);
                    end
                    bdq_pkg::REQ_INS_BEFORE_LAST:
                    begin
                        count_next = count_reg + CW'(1);
                    end
                    bdq_pkg::REQ_REMOVE_SECOND:
                    begin
                        head_next  = addr_a_reg;
                        count_next = count_reg - CW'(1);
                    end
                    default:
                    begin
                        head_next = head_reg;
                    end
                endcase
            end

            S_OUT:
            begin
                if (!rsp_stall)
                begin
                    state_next = S_IDLE;
                end
            end

            S_DUMP:
            begin
                // The read address runs one entry ahead on each taken response so
                // that the registered read data is ready in the following cycle.
                raddr = dptr_reg;
                if (!rsp_stall)
                begin
                    if (dump_last)
                    begin
                        dpos_next  = '0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        raddr     = dptr_inc;
                        dptr_next = dptr_inc;
                        dpos_next = dpos_reg + AW'(1);
                    end
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            head_reg  <= '0;
            count_reg <= '0;
            dpos_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            dpos_reg  <= dpos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        val_reg        <= val_next;
        addr_a_reg     <= addr_a_next;
        addr_b_reg     <= addr_b_next;
        res_val_reg    <= res_val_next;
        res_status_reg <= res_status_next;
        dptr_reg       <= dptr_next;
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q <= mem[raddr];
    end

    assign req_stall = (state_reg != S_IDLE);
    assign rsp_valid = (state_reg == S_OUT) || (state_reg == S_DUMP);

    always_comb
    begin
        rsp.entry_count = bdq_pkg::COUNT_OUT_W'(count_reg);
        if (state_reg == S_DUMP)
        begin
            rsp.value_out   = mem_q;
            rsp.status      = bdq_pkg::ST_OK;
            rsp.last_of_run = dump_last;
        end
        else
        begin
            rsp.value_out   = res_val_reg;
            rsp.status      = res_status_reg;
            rsp.last_of_run = 1'b1;
        end
    end

endmodule

/* hdl/bdq_checker.sv */
// ----------------------------------------------------------------------------
// bdq_checker
// Port-level checks of the bounded deque core, attached by bind.
// ----------------------------------------------------------------------------
`include "bounded_deque_positional_ops_core_assert.svh"

module bdq_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    input  logic               req_stall,
    input  logic               rsp_valid,
    input  logic               rsp_stall,
    input  bdq_pkg::rsp_item_t rsp
);

    logic req_taken;
    logic mid_run;
    logic status_ok;
    logic rsp_held;

    assign req_taken = req_valid && !req_stall;
    assign mid_run   = rsp_valid && !rsp.last_of_run;
    assign status_ok = (rsp.status == bdq_pkg::ST_OK);
    assign rsp_held  = rsp_valid && rsp_stall;

    // A new request is never taken while a response is still offered.
    `BDQ_ASSERT_NOW(a_busy_while_rsp, rsp_valid, req_stall, "request taken during response")

    // Every accepted request leaves the block busy, with req_stall raised, after it is taken.
    `BDQ_ASSERT_NEXT(a_stall_after_req, req_taken, req_stall, "no busy after request")

    // A response with last_of_run low (only a non-final dump response) has OK status.
    `BDQ_ASSERT_NOW(a_mid_run_ok, mid_run, status_ok, "non-final response with error status")

    // A stalled response keeps its payload.
    `BDQ_ASSERT_NEXT(a_rsp_hold, rsp_held, rsp_valid && $stable(rsp), "stalled response changed")

endmodule

bind bounded_deque_positional_ops_core bdq_checker u_bdq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
